>>> design/tnms_pkg.sv
`timescale 1ns / 1ps

package tnms_pkg;

  localparam int TAG_W      = 16;
  localparam int KEY_W      = 32;
  localparam int LIMIT_W    = 5;
  localparam int MASK_W     = 4;
  localparam int KIU_W      = 3;
  localparam int KNUM_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEYS_IN_USE     = 2'd2;

  typedef struct packed {
    logic take_cand;
    logic take_prev;
    logic take_next;
  } cell_ctrl_t;

endpackage

>>> design/top_n_multikey_selector.sv
`timescale 1ns / 1ps
// channel   | handshake           | payload
// request   | in_valid, in_stall  | record_tag, key_zero..key_three, final_record
// result    | res_valid, res_stall| out_tag, out_key_zero, out_valid, out_last
// config    | cfg_we              | cfg_index, cfg_data
//
// A request is taken as it arrives: every cell compares it with its entry and the
// row shifts at once, so records enter back to back, one a cycle while in_stall is low.
// After a final record the row shifts toward cell 0 one entry per result taken:
// the emission gives max(1, count) results, during which in_stall is high.
// rst clears the fill count and the emission state; entries are not cleared.
// res_stall holds cell 0 and the result fields.

module top_n_multikey_selector #(
  parameter int CAPACITY  = 16,
  parameter int KEY_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tnms_pkg::TAG_W-1:0]          record_tag,
  input  logic signed [tnms_pkg::KEY_W-1:0]   key_zero,
  input  logic signed [tnms_pkg::KEY_W-1:0]   key_one,
  input  logic signed [tnms_pkg::KEY_W-1:0]   key_two,
  input  logic signed [tnms_pkg::KEY_W-1:0]   key_three,
  input  logic                                final_record,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [tnms_pkg::TAG_W-1:0]          out_tag,
  output logic signed [tnms_pkg::KEY_W-1:0]   out_key_zero,
  output logic                                out_valid,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [tnms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tnms_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > tnms_pkg::LIMIT_W) ? CW : tnms_pkg::LIMIT_W;

  logic [tnms_pkg::LIMIT_W-1:0] keep_limit;
  logic [tnms_pkg::MASK_W-1:0]  descending_mask;
  logic [tnms_pkg::KIU_W-1:0]   keys_in_use;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          emitting;
  logic          empty_mark;

  logic [LW-1:0] lim_wide;
  logic [CW-1:0] lim;
  logic [CW-1:0] cnt_eff;
  logic          full;
  logic          ins;
  logic          in_acc;
  logic          res_acc;
  logic          shift_out;

  logic [tnms_pkg::KNUM_W-1:0] knum;
  logic [KEY_COUNT-1:0]        desc;

  logic [KEY_COUNT-1:0][tnms_pkg::KEY_W-1:0] cand_keys;
  logic [tnms_pkg::TAG_W-1:0]                c_tag  [CAPACITY];
  logic [KEY_COUNT-1:0][tnms_pkg::KEY_W-1:0] c_keys [CAPACITY];
  logic [CAPACITY-1:0]                       c_beat;
  logic [CAPACITY:0]                         ahead;

  assign in_acc   = in_valid && !in_stall;
  assign res_acc  = res_valid && !res_stall;
  assign in_stall = emitting;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit      <= 5'd16;
      descending_mask <= '0;
      keys_in_use     <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tnms_pkg::REG_KEEP_LIMIT:      keep_limit      <= cfg_data;
        tnms_pkg::REG_DESCENDING_MASK: descending_mask <= cfg_data[tnms_pkg::MASK_W-1:0];
        tnms_pkg::REG_KEYS_IN_USE:     keys_in_use     <= cfg_data[tnms_pkg::KIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    knum = tnms_pkg::KNUM_W'(keys_in_use);
    if (knum == '0) knum = tnms_pkg::KNUM_W'(1);
    if (knum > tnms_pkg::KNUM_W'(KEY_COUNT)) knum = tnms_pkg::KNUM_W'(KEY_COUNT);
  end

  assign lim_wide = (LW'(keep_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(keep_limit);
  assign lim      = lim_wide[CW-1:0];
  assign cnt_eff  = (count > lim) ? lim : count;
  assign full     = (cnt_eff == lim);
  assign ins      = in_acc && (!full || ahead[CAPACITY]);
  assign shift_out = res_acc && !empty_mark && (count != CW'(1));

  assign count_next = (ins && !full) ? cnt_eff + CW'(1) : cnt_eff;

  genvar g;
  generate
    for (g = 0; g < KEY_COUNT; g++) begin : g_keys
      if (g == 0) begin : g_k0
        assign cand_keys[g] = key_zero;
      end else if (g == 1) begin : g_k1
        assign cand_keys[g] = key_one;
      end else if (g == 2) begin : g_k2
        assign cand_keys[g] = key_two;
      end else if (g == 3) begin : g_k3
        assign cand_keys[g] = key_three;
      end else begin : g_kz
        assign cand_keys[g] = '0;
      end
      if (g < tnms_pkg::MASK_W) begin : g_dm
        assign desc[g] = descending_mask[g];
      end else begin : g_dz
        assign desc[g] = 1'b0;
      end
    end
  endgenerate

  assign ahead[0] = 1'b0;

  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cells
      tnms_pkg::cell_ctrl_t ctrl;
      logic occ;
      logic [tnms_pkg::TAG_W-1:0]                p_tag;
      logic [KEY_COUNT-1:0][tnms_pkg::KEY_W-1:0] p_keys;
      logic [tnms_pkg::TAG_W-1:0]                n_tag;
      logic [KEY_COUNT-1:0][tnms_pkg::KEY_W-1:0] n_keys;

      assign occ = (CW'(g) < cnt_eff);
      assign ahead[g+1] = ahead[g] | (c_beat[g] & occ);

      assign ctrl.take_cand = ins && !ahead[g] &&
                              ((c_beat[g] && occ) || (CW'(g) == cnt_eff));
      assign ctrl.take_prev = ins && ahead[g] &&
                              (full ? (CW'(g) < cnt_eff) : (CW'(g) <= cnt_eff));
      assign ctrl.take_next = shift_out;

      if (g == 0) begin : g_first
        assign p_tag  = record_tag;
        assign p_keys = cand_keys;
      end else begin : g_mid
        assign p_tag  = c_tag[g-1];
        assign p_keys = c_keys[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign n_tag  = c_tag[g];
        assign n_keys = c_keys[g];
      end else begin : g_inner
        assign n_tag  = c_tag[g+1];
        assign n_keys = c_keys[g+1];
      end

      tnms_cell #(.KEY_COUNT(KEY_COUNT)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .knum      (knum),
        .desc      (desc),
        .cand_tag  (record_tag),
        .cand_keys (cand_keys),
        .prev_tag  (p_tag),
        .prev_keys (p_keys),
        .next_tag  (n_tag),
        .next_keys (n_keys),
        .tag       (c_tag[g]),
        .keys      (c_keys[g]),
        .beat      (c_beat[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      emitting   <= 1'b0;
      empty_mark <= 1'b0;
    end else if (emitting) begin
      if (res_acc) begin
        if (empty_mark || count == CW'(1)) begin
          emitting   <= 1'b0;
          empty_mark <= 1'b0;
          count      <= '0;
        end else begin
          count <= count - CW'(1);
        end
      end
    end else if (in_acc) begin
      count <= count_next;
      if (final_record) begin
        emitting   <= 1'b1;
        empty_mark <= (count_next == '0);
      end
    end
  end

  assign res_valid    = emitting;
  assign out_tag      = empty_mark ? '0 : c_tag[0];
  assign out_key_zero = empty_mark ? '0 : $signed(c_keys[0][0]);
  assign out_valid    = !empty_mark;
  assign out_last     = empty_mark || (count == CW'(1));

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_final_emits: assert property (@(posedge clk) disable iff (rst)
    in_acc && final_record |=> res_valid)
    else $error("no emission after final record");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res_acc && out_last |=> !res_valid && count == '0)
    else $error("emission continued past last result");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_last && count == '0)
    else $error("empty marker not alone");

endmodule

>>> design/tnms_cell.sv
`timescale 1ns / 1ps

module tnms_cell #(
  parameter int KEY_COUNT = 4
) (
  input  logic                                        clk,
  input  tnms_pkg::cell_ctrl_t                        ctrl,
  input  logic [tnms_pkg::KNUM_W-1:0]                 knum,
  input  logic [KEY_COUNT-1:0]                        desc,
  input  logic [tnms_pkg::TAG_W-1:0]                  cand_tag,
  input  logic [KEY_COUNT-1:0][tnms_pkg::KEY_W-1:0]   cand_keys,
  input  logic [tnms_pkg::TAG_W-1:0]                  prev_tag,
  input  logic [KEY_COUNT-1:0][tnms_pkg::KEY_W-1:0]   prev_keys,
  input  logic [tnms_pkg::TAG_W-1:0]                  next_tag,
  input  logic [KEY_COUNT-1:0][tnms_pkg::KEY_W-1:0]   next_keys,
  output logic [tnms_pkg::TAG_W-1:0]                  tag,
  output logic [KEY_COUNT-1:0][tnms_pkg::KEY_W-1:0]   keys,
  output logic                                        beat
);

  // first differing key in use decides
  always_comb begin
    beat = 1'b0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if ((tnms_pkg::KNUM_W'(k) < knum) && (cand_keys[k] != keys[k])) begin
        beat = desc[k] ? ($signed(cand_keys[k]) > $signed(keys[k]))
                       : ($signed(cand_keys[k]) < $signed(keys[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.take_cand) begin
      tag  <= cand_tag;
      keys <= cand_keys;
    end else if (ctrl.take_prev) begin
      tag  <= prev_tag;
      keys <= prev_keys;
    end else if (ctrl.take_next) begin
      tag  <= next_tag;
      keys <= next_keys;
    end
  end

endmodule
